// ----- hw/rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, defaults and operation/status codes for the deque unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DefaultDepth     = 1024;
  localparam int DefaultDataWidth = 32;

  localparam int OpWidth     = 3;
  localparam int ValueWidth  = 32;
  localparam int CountWidth  = 11;
  localparam int StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OpNone      = 3'd0,
    OpPushBack  = 3'd1,
    OpPushFront = 3'd2,
    OpPopFront  = 3'd3,
    OpPopBack   = 3'd4
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StUnder = 2'd1,
    StOver  = 2'd2
  } status_e;

endpackage

// ----- hw/rtl/deq_if.sv -----
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Request channel (operation and push value) and response channel.
// ----------------------------------------------------------------------------
interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::OpWidth-1:0]         operation;
  logic signed [deq_pkg::ValueWidth-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [deq_pkg::ValueWidth-1:0] front_value;
  logic signed [deq_pkg::ValueWidth-1:0] back_value;
  logic [deq_pkg::CountWidth-1:0]        entry_count;
  logic                                  is_empty;
  logic [deq_pkg::StatusWidth-1:0]       status;

  modport source (output valid, output front_value, output back_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface

// ----- hw/rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Deque RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque held in a ring buffer RAM, with head/tail pointers, a count
// and cached front/back words. One response per request.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                               | beat
//  --------+-----+------------------------------------------------------+-----
//  in_i    | in  | operation, push_value                                | 1
//  out_o   | out | front_value, back_value, entry_count, is_empty,      | 1
//          |     | status                                               |
//
//  The accept cycle updates pointers and issues the RAM write or read; in
//  S_DONE, once the response register is free, the unit merges the registered
//  RAM read data into the cached front/back word and loads the response
//  register. No new request is taken until then.
//  Reset clears pointers and count; RAM contents need no clearing.
//  A stalled response holds the unit in S_DONE; in_i.ready stays low.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DefaultDepth,
  parameter int DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  deq_req_if.sink     in_i,
  deq_rsp_if.source   out_o
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic state_q, state_d;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  logic                  ld_front_q, ld_front_d;
  logic                  ld_back_q, ld_back_d;
  status_e               status_q, status_d;

  logic                                   out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0]           out_front_q, out_front_d;
  logic signed [ValueWidth-1:0]           out_back_q, out_back_d;
  logic [CountWidth-1:0]                  out_count_q, out_count_d;
  logic                                   out_empty_q, out_empty_d;
  logic [StatusWidth-1:0]                 out_status_q, out_status_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH-1:0] wdata;
  logic [63:0]           push_ext;

  logic                  accept;
  logic                  is_full, is_void, out_free;
  logic [DATA_WIDTH-1:0] front_fin, back_fin;
  logic [63:0]           front_wide, back_wide;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  assign push_ext = {32'd0, in_i.push_value};
  assign wdata    = push_ext[DATA_WIDTH-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_void    = (count_q == '0);
  assign out_free   = !out_valid_q || out_o.ready;

  assign front_fin  = ld_front_q ? ram_rdata : front_q;
  assign back_fin   = ld_back_q ? ram_rdata : back_q;
  assign front_wide = 64'($signed(front_fin));
  assign back_wide  = 64'($signed(back_fin));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    front_d      = front_q;
    back_d       = back_q;
    ld_front_d   = ld_front_q;
    ld_back_d    = ld_back_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_DONE;
          ld_front_d = 1'b0;
          ld_back_d  = 1'b0;
          status_d   = StOk;
          case (in_i.operation)
            OpPushBack: begin
              if (is_full) begin
                status_d = StOver;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = tail_q;
                tail_d    = ring_next(tail_q);
                count_d   = count_q + CW'(1);
                back_d    = wdata;
                if (is_void) begin
                  front_d = wdata;
                end
              end
            end
            OpPushFront: begin
              if (is_full) begin
                status_d = StOver;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_prev(head_q);
                head_d    = ring_prev(head_q);
                count_d   = count_q + CW'(1);
                front_d   = wdata;
                if (is_void) begin
                  back_d = wdata;
                end
              end
            end
            OpPopFront: begin
              if (is_void) begin
                status_d = StUnder;
              end else begin
                head_d     = ring_next(head_q);
                count_d    = count_q - CW'(1);
                // new front lives one slot past the old head
                ram_re     = 1'b1;
                ram_raddr  = ring_next(head_q);
                ld_front_d = 1'b1;
              end
            end
            OpPopBack: begin
              if (is_void) begin
                status_d = StUnder;
              end else begin
                tail_d    = ring_prev(tail_q);
                count_d   = count_q - CW'(1);
                // new back sits two slots below the old tail
                ram_re    = 1'b1;
                ram_raddr = ring_prev(ring_prev(tail_q));
                ld_back_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d      = S_IDLE;
          front_d      = front_fin;
          back_d       = back_fin;
          ld_front_d   = 1'b0;
          ld_back_d    = 1'b0;
          out_valid_d  = 1'b1;
          out_empty_d  = is_void;
          out_front_d  = is_void ? -32'sd1 : $signed(front_wide[31:0]);
          out_back_d   = is_void ? -32'sd1 : $signed(back_wide[31:0]);
          out_count_d  = CountWidth'(count_q);
          out_status_d = status_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ld_front_q  <= 1'b0;
      ld_back_q   <= 1'b0;
      status_q    <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ld_front_q  <= ld_front_d;
      ld_back_q   <= ld_back_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    back_q       <= back_d;
    out_front_q  <= out_front_d;
    out_back_q   <= out_back_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  deq_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = out_front_q;
  assign out_o.back_value  = out_back_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.status      = out_status_q;

endmodule

// ----- hw/rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level assertions for the deque unit, attached by bind.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int DEPTH = deq_pkg::DefaultDepth
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_i,
  input logic                                    out_valid_i,
  input logic                                    out_ready_i,
  input logic signed [deq_pkg::ValueWidth-1:0]   front_value_i,
  input logic signed [deq_pkg::ValueWidth-1:0]   back_value_i,
  input logic [deq_pkg::CountWidth-1:0]          entry_count_i,
  input logic                                    is_empty_i,
  input logic [deq_pkg::StatusWidth-1:0]         status_i
);

  import deq_pkg::*;

  // stalled response keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(front_value_i)
      && $stable(back_value_i) && $stable(entry_count_i) && $stable(status_i))
    else $error("response changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (entry_count_i == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |-> front_value_i == -32'sd1 && back_value_i == -32'sd1)
    else $error("empty queue must report -1 values");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == StOver |-> entry_count_i == CountWidth'(DEPTH))
    else $error("overflow reported on a queue that is not full");

  // an accepted transaction occupies the unit, so requests are not taken back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken back to back");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .front_value_i (out_o.front_value),
  .back_value_i  (out_o.back_value),
  .entry_count_i (out_o.entry_count),
  .is_empty_i    (out_o.is_empty),
  .status_i      (out_o.status)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque unit testbench
// Sends push/pop requests at both ends of the deque, including empty pops,
// pushes onto a full store and unused opcodes. Each response is compared
// with a ring-buffer predictor kept inside the bench. Random gaps on the
// request side and random stalls on the response side are applied.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int Depth         = DefaultDepth;
  localparam int ClkHalfPeriod = 1;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 8;

  localparam logic [OpWidth-1:0] OpSpareFirst = 3'd5;
  localparam logic [OpWidth-1:0] OpSpareLast  = 3'd7;

  localparam logic signed [ValueWidth-1:0] EmptyMark = -1;
  localparam logic signed [ValueWidth-1:0] ValMax    = 32'h7FFF_FFFF;
  localparam logic signed [ValueWidth-1:0] ValMin    = 32'h8000_0000;

  typedef struct packed {
    logic signed [ValueWidth-1:0] front_value;
    logic signed [ValueWidth-1:0] back_value;
    logic [CountWidth-1:0]        entry_count;
    logic                         is_empty;
    status_e                      status;
  } deq_rsp_t;

  logic clk_i;
  logic rst_ni;

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  double_ended_queue_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // predicted deque contents
  logic signed [ValueWidth-1:0] ring_words [Depth];
  int ring_head;
  int ring_tail;
  int ring_fill;

  deq_rsp_t pending_rsp [$];

  int  err_count;
  int  sent_count;
  int  checked_count;
  int  peak_fill;
  int  under_count;
  int  over_count;
  int  burst_left;
  int  cycle_count;
  bit  gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalfPeriod clk_i = ~clk_i;
  end

  function automatic deq_rsp_t step_deque(input logic [OpWidth-1:0] op,
                                          input logic signed [ValueWidth-1:0] val);
    deq_rsp_t r;
    r.status = StOk;
    if (op == OpPushBack || op == OpPushFront) begin
      if (ring_fill >= Depth) begin
        r.status = StOver;
      end else if (op == OpPushBack) begin
        ring_words[ring_tail] = val;
        ring_tail = (ring_tail + 1) % Depth;
        ring_fill++;
      end else begin
        ring_head = (ring_head + Depth - 1) % Depth;
        ring_words[ring_head] = val;
        ring_fill++;
      end
    end else if (op == OpPopFront || op == OpPopBack) begin
      if (ring_fill == 0) begin
        r.status = StUnder;
      end else if (op == OpPopFront) begin
        ring_head = (ring_head + 1) % Depth;
        ring_fill--;
      end else begin
        ring_tail = (ring_tail + Depth - 1) % Depth;
        ring_fill--;
      end
    end
    if (ring_fill == 0) begin
      r.front_value = EmptyMark;
      r.back_value  = EmptyMark;
      r.is_empty    = 1'b1;
    end else begin
      r.front_value = ring_words[ring_head];
      r.back_value  = ring_words[(ring_tail + Depth - 1) % Depth];
      r.is_empty    = 1'b0;
    end
    r.entry_count = CountWidth'(ring_fill);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so back-to-back transactions need no toggle.
  task automatic send_item(input logic [OpWidth-1:0] op,
                           input logic signed [ValueWidth-1:0] val);
    deq_rsp_t r;
    if (gaps_on && burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.push_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    r = step_deque(op, val);
    pending_rsp = {pending_rsp, r};
    sent_count++;
    if (ring_fill > peak_fill) peak_fill = ring_fill;
    if (r.status == StUnder) under_count++;
    if (r.status == StOver) over_count++;
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  function automatic logic [OpWidth-1:0] pick_op(input int push_pct, input int noise_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < noise_pct) begin
      if ($urandom_range(0, 1)) return OpNone;
      return OpWidth'($urandom_range(OpSpareFirst, OpSpareLast));
    end
    if (roll < noise_pct + push_pct) return $urandom_range(0, 1) ? OpPushBack : OpPushFront;
    return $urandom_range(0, 1) ? OpPopFront : OpPopBack;
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ValMax;
      1:       return ValMin;
      2:       return EmptyMark;
      default: return ValueWidth'($urandom);
    endcase
  endfunction

  task automatic test_empty_underflow();
    gaps_on = 1'b0;
    send_item(OpPopFront, pick_value());
    send_item(OpPopBack, pick_value());
    send_item(OpNone, pick_value());
  endtask

  task automatic test_value_extremes();
    gaps_on = 1'b0;
    send_item(OpPushBack, ValMax);
    send_item(OpPushBack, ValMin);
    send_item(OpPushFront, '0);
    send_item(OpPushFront, EmptyMark);  // stored -1 must not read as empty
    send_item(OpPopFront, pick_value());
    send_item(OpPopBack, pick_value());
    send_item(OpPopFront, pick_value());
    send_item(OpPopBack, pick_value());  // last entry leaves through the back
    send_item(OpPopBack, pick_value());
    send_item(OpPushFront, 32'h5555_5555);
    send_item(OpPopBack, pick_value());
  endtask

  task automatic test_spare_codes();
    gaps_on = 1'b0;
    send_item(OpPushBack, pick_value());
    for (int c = OpSpareFirst; c <= OpSpareLast; c++) begin
      send_item(OpWidth'(c), pick_value());
    end
    send_item(OpNone, pick_value());
    send_item(OpPopFront, pick_value());
  endtask

  task automatic test_random_churn(input int n, input int push_pct, input int noise_pct);
    gaps_on = 1'b1;
    repeat (n) send_item(pick_op(push_pct, noise_pct), pick_value());
  endtask

  task automatic test_fill_to_overflow();
    while (ring_fill < Depth) begin
      gaps_on = ((ring_fill / 256) % 2) != 0;
      send_item($urandom_range(0, 1) ? OpPushBack : OpPushFront, pick_value());
    end
    send_item(OpPushBack, pick_value());
    send_item(OpPushFront, pick_value());
    gaps_on = 1'b1;
    repeat (40) send_item(pick_op(60, 5), pick_value());
    while (ring_fill < Depth) send_item(OpPushFront, pick_value());
    send_item(OpPushFront, pick_value());
  endtask

  always @(posedge clk_i) begin : rsp_check
    deq_rsp_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response transaction with no request outstanding");
        err_count++;
      end else begin
        exp_r = pending_rsp[0];
        pending_rsp.delete(0);
        checked_count++;
        if (rsp_if.front_value !== exp_r.front_value) begin
          $error("front_value: expected %0d, got %0d", exp_r.front_value, rsp_if.front_value);
          err_count++;
        end
        if (rsp_if.back_value !== exp_r.back_value) begin
          $error("back_value: expected %0d, got %0d", exp_r.back_value, rsp_if.back_value);
          err_count++;
        end
        if (rsp_if.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, rsp_if.entry_count);
          err_count++;
        end
        if (rsp_if.is_empty !== exp_r.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_r.is_empty, rsp_if.is_empty);
          err_count++;
        end
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
          err_count++;
        end
      end
    end
  end

  // response side: ready follows a randomly reloaded 8-bit mask with bit 0 always set
  initial begin : rsp_stall_pattern
    logic [7:0] mask;
    int         phase;
    rsp_if.ready = 1'b0;
    mask  = '1;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (phase % 32 == 0) begin
        mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      rsp_if.ready <= mask[phase % 8];
      phase++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_seq
    req_if.valid      = 1'b0;
    req_if.operation  = OpNone;
    req_if.push_value = '0;
    rst_ni            = 1'b0;
    ring_head     = 0;
    ring_tail     = 0;
    ring_fill     = 0;
    err_count     = 0;
    sent_count    = 0;
    checked_count = 0;
    peak_fill     = 0;
    under_count   = 0;
    over_count    = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_underflow();
    test_value_extremes();
    pause_until_drained();
    test_spare_codes();
    test_random_churn(200, 45, 15);
    pause_until_drained();
    test_fill_to_overflow();
    test_random_churn(50, 50, 10);
    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked, peak fill %0d of %0d",
             sent_count, checked_count, peak_fill, Depth);
    $display("%0d underflow and %0d overflow transactions seen", under_count, over_count);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
